[rtl/bmh_pkg.sv]
// Shared codes for the binary min-heap priority queue.
package bmh_pkg;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    typedef enum logic {
        FUNC_INSERT = 1'b0,
        FUNC_POP    = 1'b1
    } func_t;

    localparam int KEY_W   = 32;
    localparam int CFG_W   = 8;
    localparam int COUNT_W = 8;

endpackage

[rtl/bmh_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module bmh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/binary_min_heap_top.sv]
// Top level of the binary min-heap priority queue: sequencer, compare unit, result register.
//
// Usage:
//   Input channel (in_valid/in_ready, func, key_in) carries one request per
//   transfer: func insert stores key_in, func pop removes the minimum key.
//   Output channel (out_valid/out_ready, key_out, status, count_after) gives
//   exactly one result per request, in request order.
//   cfg_we/cfg_wdata write max_entries (limit, capped at DEPTH); write only
//   while the block is idle.
// Sequencing:
//   Keys live in one RAM (one write and one registered read per cycle) and
//   a single signed comparator is shared by every sift step.
//   Insert: the key climbs while smaller than its parent; an empty heap takes
//   it at the root. Pop: the root is the result and the last key sinks while
//   larger than its smaller child, unless the pop empties the heap. Refused
//   requests (full or empty) go straight to the result. in_ready is high only
//   while the sequencer is idle; one request at a time.
// Reset: count clears to zero, max_entries returns to 99; RAM contents are
//   left as they are and are never read before being written.
// Stall: the result sits in an output register; the next request may be
//   taken while it waits, but its own result holds until out_ready frees it.
module binary_min_heap_top
    import bmh_pkg::*;
#(
    parameter int DEPTH = 128
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    func,
    input  logic signed [KEY_W-1:0] key_in,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [KEY_W-1:0] key_out,
    output logic [1:0]              status,
    output logic [COUNT_W-1:0]      count_after,
    input  logic                    cfg_we,
    input  logic [CFG_W-1:0]        cfg_wdata
);

    localparam int AW = $clog2(DEPTH);
    localparam int PW = $clog2(DEPTH + 1);          // heap position 1..DEPTH, count 0..DEPTH
    localparam int LW = (PW > CFG_W) ? PW : CFG_W;  // common width for the limit check

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_CMP,
        S_UP_WR,
        S_POP_LAST,
        S_POP_V,
        S_DN_RDL,
        S_DN_RDR,
        S_DN_SEL,
        S_DN_CMP,
        S_DONE
    } state_t;

    state_t                  state_reg, state_next;
    logic [PW-1:0]           count_reg, count_next;
    logic [PW-1:0]           pos_reg, pos_next;
    logic [PW-1:0]           cpos_reg, cpos_next;
    logic [KEY_W-1:0]        v_reg, v_next;        // key being sifted
    logic [KEY_W-1:0]        left_reg, left_next;
    logic [KEY_W-1:0]        child_reg, child_next;
    logic [KEY_W-1:0]        res_key_reg, res_key_next;
    status_t                 res_status_reg, res_status_next;
    logic [CFG_W-1:0]        max_entries_reg, max_entries_next;
    logic                    out_valid_reg, out_valid_next;
    logic [KEY_W-1:0]        out_key_reg, out_key_next;
    status_t                 out_status_reg, out_status_next;
    logic [COUNT_W-1:0]      out_count_reg, out_count_next;

    // RAM port
    logic                    ram_we;
    logic [AW-1:0]           ram_waddr;
    logic [KEY_W-1:0]        ram_wdata;
    logic [AW-1:0]           ram_raddr;
    logic [KEY_W-1:0]        ram_rdata;

    // Shared compare unit
    logic [KEY_W-1:0]        cmp_a, cmp_b;
    logic                    cmp_lt;

    // Limit and count helpers
    logic [LW-1:0]           max_ext, depth_ext, limit, count_ext;
    logic [PW:0]             child_pos_w;
    logic [PW-1:0]           pos_up;

    function automatic logic [AW-1:0] pos_to_addr(input logic [PW-1:0] p);
        logic [PW-1:0] s;
        s = p - 1'b1;
        return s[AW-1:0];
    endfunction

    bmh_ram #(
        .WIDTH (KEY_W),
        .DEPTH (DEPTH)
    ) u_heap_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Operand select for the one comparator: a < b, signed
    always_comb
    begin
        cmp_a = child_reg;
        cmp_b = v_reg;
        unique case (state_reg)
            S_UP_CMP:
            begin
                cmp_a = v_reg;
                cmp_b = ram_rdata;
            end
            S_DN_SEL:
            begin
                cmp_a = ram_rdata;
                cmp_b = left_reg;
            end
            default:
            begin
                cmp_a = child_reg;
                cmp_b = v_reg;
            end
        endcase
    end

    assign cmp_lt = $signed(cmp_a) < $signed(cmp_b);

    assign max_ext     = LW'(max_entries_reg);
    assign depth_ext   = LW'(DEPTH);
    assign limit       = (max_ext < depth_ext) ? max_ext : depth_ext;
    assign count_ext   = LW'(count_reg);
    assign child_pos_w = {pos_reg, 1'b0};
    assign pos_up      = pos_reg >> 1;

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        pos_next         = pos_reg;
        cpos_next        = cpos_reg;
        v_next           = v_reg;
        left_next        = left_reg;
        child_next       = child_reg;
        res_key_next     = res_key_reg;
        res_status_next  = res_status_reg;
        max_entries_next = cfg_we ? cfg_wdata : max_entries_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        out_key_next     = out_key_reg;
        out_status_next  = out_status_reg;
        out_count_next   = out_count_reg;
        ram_we           = 1'b0;
        ram_waddr        = pos_to_addr(pos_reg);
        ram_wdata        = v_reg;
        ram_raddr        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    res_key_next    = '0;
                    res_status_next = STATUS_OK;
                    if (func == FUNC_INSERT)
                    begin
                        if (count_ext >= limit)
                        begin
                            res_status_next = STATUS_FULL;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            count_next = count_reg + 1'b1;
                            pos_next   = count_reg + 1'b1;
                            v_next     = key_in;
                            if (count_reg == '0)
                            begin
                                // first key goes straight to the root
                                ram_we     = 1'b1;
                                ram_waddr  = '0;
                                ram_wdata  = key_in;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                ram_raddr  = pos_to_addr(PW'((count_reg + 1'b1) >> 1));
                                state_next = S_UP_CMP;
                            end
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            res_status_next = STATUS_EMPTY;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            ram_raddr  = '0;
                            state_next = S_POP_LAST;
                        end
                    end
                end
            end

            // rdata holds the parent of pos
            S_UP_CMP:
            begin
                if (cmp_lt)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = ram_rdata;
                    pos_next  = pos_up;
                    if (pos_up == PW'(1))
                    begin
                        state_next = S_UP_WR;
                    end
                    else
                    begin
                        ram_raddr = pos_to_addr(pos_up >> 1);
                    end
                end
                else
                begin
                    ram_we     = 1'b1;
                    state_next = S_DONE;
                end
            end

            S_UP_WR:
            begin
                ram_we     = 1'b1;
                state_next = S_DONE;
            end

            S_POP_LAST:
            begin
                res_key_next = ram_rdata;
                ram_raddr    = pos_to_addr(count_reg);
                state_next   = S_POP_V;
            end

            S_POP_V:
            begin
                v_next     = ram_rdata;
                count_next = count_reg - 1'b1;
                pos_next   = PW'(1);
                if (count_reg == PW'(1))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_DN_RDL;
                end
            end

            S_DN_RDL:
            begin
                if (child_pos_w > {1'b0, count_reg})
                begin
                    ram_we     = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    cpos_next  = child_pos_w[PW-1:0];
                    ram_raddr  = pos_to_addr(child_pos_w[PW-1:0]);
                    state_next = S_DN_RDR;
                end
            end

            S_DN_RDR:
            begin
                left_next = ram_rdata;
                if (cpos_reg < count_reg)
                begin
                    ram_raddr  = pos_to_addr(cpos_reg + 1'b1);
                    state_next = S_DN_SEL;
                end
                else
                begin
                    child_next = ram_rdata;
                    state_next = S_DN_CMP;
                end
            end

            // right child wins only when strictly smaller
            S_DN_SEL:
            begin
                if (cmp_lt)
                begin
                    child_next = ram_rdata;
                    cpos_next  = cpos_reg + 1'b1;
                end
                else
                begin
                    child_next = left_reg;
                end
                state_next = S_DN_CMP;
            end

            S_DN_CMP:
            begin
                ram_we = 1'b1;
                if (cmp_lt)
                begin
                    ram_wdata  = child_reg;
                    pos_next   = cpos_reg;
                    state_next = S_DN_RDL;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_key_next    = res_key_reg;
                    out_status_next = res_status_reg;
                    out_count_next  = count_ext[COUNT_W-1:0];
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            count_reg       <= '0;
            pos_reg         <= '0;
            cpos_reg        <= '0;
            v_reg           <= '0;
            left_reg        <= '0;
            child_reg       <= '0;
            res_key_reg     <= '0;
            res_status_reg  <= STATUS_OK;
            max_entries_reg <= CFG_W'(99);
            out_valid_reg   <= 1'b0;
            out_key_reg     <= '0;
            out_status_reg  <= STATUS_OK;
            out_count_reg   <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            count_reg       <= count_next;
            pos_reg         <= pos_next;
            cpos_reg        <= cpos_next;
            v_reg           <= v_next;
            left_reg        <= left_next;
            child_reg       <= child_next;
            res_key_reg     <= res_key_next;
            res_status_reg  <= res_status_next;
            max_entries_reg <= max_entries_next;
            out_valid_reg   <= out_valid_next;
            out_key_reg     <= out_key_next;
            out_status_reg  <= out_status_next;
            out_count_reg   <= out_count_next;
        end
    end

    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = out_valid_reg;
    assign key_out     = out_key_reg;
    assign status      = out_status_reg;
    assign count_after = out_count_reg;

endmodule
